// ----- rtl/core/prma_pkg.sv -----
// Shared constants, codes and types of the pixel region mask pipeline.
// No dependencies; every other file in rtl/core imports this package.
package prma_pkg;

	// Width of pixel coordinates and of the coordinate registers.
	localparam int COORD_BITS = 12;
	// Fractional bits of the cone distance.
	localparam int FRAC_BITS = 8;
	// Width of one squared coordinate difference.
	localparam int PROD_W = 2 * COORD_BITS;
	// Width of dx*dx + dy*dy.
	localparam int SQ_W = 2 * COORD_BITS + 1;
	// Width of the fixed-point radius.
	localparam int RAD_W = COORD_BITS + FRAC_BITS;
	// Width of the fixed-point distance, one bit more than the radius.
	localparam int ROOT_W = COORD_BITS + FRAC_BITS + 1;
	// Quotient bits of the cone falloff.
	localparam int QUO_W = 8;
	// Width of the configuration register index.
	localparam int CFG_IDX_W = 4;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_RECT = 2'd0;
	localparam mode_t MODE_DISC = 2'd1;
	localparam mode_t MODE_CONE = 2'd2;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_MASK_MODE   = reg_idx_t'(0);
	localparam reg_idx_t REG_CENTER_ROW  = reg_idx_t'(1);
	localparam reg_idx_t REG_CENTER_COL  = reg_idx_t'(2);
	localparam reg_idx_t REG_RADIUS      = reg_idx_t'(3);
	localparam reg_idx_t REG_RECT_TOP    = reg_idx_t'(4);
	localparam reg_idx_t REG_RECT_LEFT   = reg_idx_t'(5);
	localparam reg_idx_t REG_RECT_BOTTOM = reg_idx_t'(6);
	localparam reg_idx_t REG_RECT_RIGHT  = reg_idx_t'(7);

	localparam logic [7:0] MASK_FULL = 8'd255;
	localparam logic [7:0] MASK_NONE = 8'd0;

	typedef struct packed {
		mode_t                 mode;
		logic [COORD_BITS-1:0] center_row;
		logic [COORD_BITS-1:0] center_col;
		logic [COORD_BITS-1:0] radius;
		logic [COORD_BITS-1:0] rect_top;
		logic [COORD_BITS-1:0] rect_left;
		logic [COORD_BITS-1:0] rect_bottom;
		logic [COORD_BITS-1:0] rect_right;
	} cfg_t;

	// Payload that rides along the pipeline next to the arithmetic.
	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] mask;
		logic       cone;
	} side_t;

endpackage

// ----- rtl/core/pixel_region_mask_apply.sv -----
// Top level of the pixel region mask: configuration registers, the pipeline
// and the output skid buffer. Depends on prma_pkg and the prma_* modules.

// The block takes one pixel per clock while the output buffer has room and returns
// it with each channel scaled by the mask of the selected mode; the pipeline length
// is set by the square root, which resolves one distance bit per stage, and the cone
// division, which resolves one quotient bit per stage.
// The pipeline moves as a whole and stalls only when the two-entry output buffer is
// full, so pix_ready comes straight from a register and a pixel is still taken in
// the cycle a finished result waits at the output. Configuration writes take effect
// at once and are meant to be made while no pixel is in flight.
module pixel_region_mask_apply (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  prma_pkg::reg_idx_t               cfg_index,
	input  logic [prma_pkg::COORD_BITS-1:0]  cfg_wdata,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic [prma_pkg::COORD_BITS-1:0]  pixel_row,
	input  logic [prma_pkg::COORD_BITS-1:0]  pixel_col,
	input  logic [7:0]                       chan_a_in,
	input  logic [7:0]                       chan_b_in,
	input  logic [7:0]                       chan_c_in,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [7:0]                       chan_a_out,
	output logic [7:0]                       chan_b_out,
	output logic [7:0]                       chan_c_out,
	output logic [7:0]                       mask_value
);
	import prma_pkg::*;

	typedef struct packed {
		logic [7:0] chan_a;
		logic [7:0] chan_b;
		logic [7:0] chan_c;
		logic [7:0] mask;
	} beat_t;

	cfg_t            cfg_q;
	logic            en;

	logic            geo_valid;
	logic [SQ_W-1:0] geo_sum;
	side_t           geo_side;

	logic              sq_valid;
	logic [ROOT_W-1:0] sq_dist;
	side_t             sq_side;

	logic  cone_valid;
	side_t cone_side;

	logic  sc_valid;
	beat_t sc_beat;
	logic  handoff;

	logic  res_valid_q, skid_valid_q;
	beat_t res_q, skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= MODE_CONE;
			cfg_q.center_row  <= '0;
			cfg_q.center_col  <= '0;
			cfg_q.radius      <= '0;
			cfg_q.rect_top    <= '0;
			cfg_q.rect_left   <= '0;
			cfg_q.rect_bottom <= '0;
			cfg_q.rect_right  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK_MODE:   cfg_q.mode        <= cfg_wdata[1:0];
				REG_CENTER_ROW:  cfg_q.center_row  <= cfg_wdata;
				REG_CENTER_COL:  cfg_q.center_col  <= cfg_wdata;
				REG_RADIUS:      cfg_q.radius      <= cfg_wdata;
				REG_RECT_TOP:    cfg_q.rect_top    <= cfg_wdata;
				REG_RECT_LEFT:   cfg_q.rect_left   <= cfg_wdata;
				REG_RECT_BOTTOM: cfg_q.rect_bottom <= cfg_wdata;
				REG_RECT_RIGHT:  cfg_q.rect_right  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The pipeline advances whenever the skid register is free to catch a beat.
	assign en        = !skid_valid_q;
	assign pix_ready = en;

	prma_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pix_valid),
		.row       (pixel_row),
		.col       (pixel_col),
		.chan_a    (chan_a_in),
		.chan_b    (chan_b_in),
		.chan_c    (chan_c_in),
		.cfg       (cfg_q),
		.out_valid (geo_valid),
		.sum_sq    (geo_sum),
		.side      (geo_side)
	);

	prma_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (geo_valid),
		.sum_sq    (geo_sum),
		.side_in   (geo_side),
		.out_valid (sq_valid),
		.dist_q8   (sq_dist),
		.side_out  (sq_side)
	);

	prma_cone u_cone (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.dist_q8   (sq_dist),
		.side_in   (sq_side),
		.radius    (cfg_q.radius),
		.out_valid (cone_valid),
		.side_out  (cone_side)
	);

	prma_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cone_valid),
		.side_in   (cone_side),
		.out_valid (sc_valid),
		.chan_a    (sc_beat.chan_a),
		.chan_b    (sc_beat.chan_b),
		.chan_c    (sc_beat.chan_c),
		.mask      (sc_beat.mask)
	);

	// A beat leaves the last pipeline stage whenever the pipeline advances.
	assign handoff = en && sc_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || res_ready) begin
			if (skid_valid_q) begin
				res_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				res_valid_q <= handoff;
			end
		end else if (handoff) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || res_ready) begin
			res_q <= skid_valid_q ? skid_q : sc_beat;
		end else if (handoff) begin
			skid_q <= sc_beat;
		end
	end

	assign res_valid  = res_valid_q;
	assign chan_a_out = res_q.chan_a;
	assign chan_b_out = res_q.chan_b;
	assign chan_c_out = res_q.chan_c;
	assign mask_value = res_q.mask;

	// The skid register only ever holds a beat queued behind a waiting result.
	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid)
		else $error("skid register holds a beat while no result is presented");

	a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(res_valid && !res_ready))
		else $error("skid register filled while the output was not stalled");

	// A channel scaled by m/255 can never exceed m.
	a_chan_within_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (chan_a_out <= mask_value) && (chan_b_out <= mask_value)
			&& (chan_c_out <= mask_value))
		else $error("scaled channel exceeds the mask value");

endmodule

// ----- rtl/core/prma_geom.sv -----
// Geometry front end: distances to the center, squared distance, rectangle and
// disc tests. Three register stages. Depends on prma_pkg.
module prma_geom (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [prma_pkg::COORD_BITS-1:0] row,
	input  logic [prma_pkg::COORD_BITS-1:0] col,
	input  logic [7:0]                     chan_a,
	input  logic [7:0]                     chan_b,
	input  logic [7:0]                     chan_c,
	input  prma_pkg::cfg_t                 cfg,
	output logic                           out_valid,
	output logic [prma_pkg::SQ_W-1:0]      sum_sq,
	output prma_pkg::side_t                side
);
	import prma_pkg::*;

	logic [COORD_BITS-1:0] row_lo, row_hi, col_lo, col_hi;
	logic [COORD_BITS-1:0] dy_c, dx_c;
	logic                  rect_hit;
	side_t                 side_c;

	logic                  vld_s1;
	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic                  disc_s1;
	side_t                 side_s1;

	logic                  vld_s2;
	logic [PROD_W-1:0]     dx2_s2, dy2_s2, r2_s2;
	logic                  disc_s2;
	side_t                 side_s2;

	logic [SQ_W-1:0]       sum_c;
	side_t                 side_s2_next;

	logic                  vld_s3;
	logic [SQ_W-1:0]       sum_s3;
	side_t                 side_s3;

	always_comb begin
		// Swapped corners still describe the span from the smaller to the larger value.
		row_lo = (cfg.rect_top < cfg.rect_bottom) ? cfg.rect_top : cfg.rect_bottom;
		row_hi = (cfg.rect_top < cfg.rect_bottom) ? cfg.rect_bottom : cfg.rect_top;
		col_lo = (cfg.rect_left < cfg.rect_right) ? cfg.rect_left : cfg.rect_right;
		col_hi = (cfg.rect_left < cfg.rect_right) ? cfg.rect_right : cfg.rect_left;
		rect_hit = (row >= row_lo) && (row <= row_hi) && (col >= col_lo) && (col <= col_hi);
		dy_c = (row > cfg.center_row) ? (row - cfg.center_row) : (cfg.center_row - row);
		dx_c = (col > cfg.center_col) ? (col - cfg.center_col) : (cfg.center_col - col);
		side_c.chan_a = chan_a;
		side_c.chan_b = chan_b;
		side_c.chan_c = chan_c;
		side_c.mask   = ((cfg.mode == MODE_RECT) && rect_hit) ? MASK_FULL : MASK_NONE;
		side_c.cone   = (cfg.mode == MODE_CONE);
	end

	always_comb begin
		sum_c = SQ_W'(dx2_s2) + SQ_W'(dy2_s2);
		side_s2_next = side_s2;
		if (disc_s2 && (sum_c <= SQ_W'(r2_s2))) begin
			side_s2_next.mask = MASK_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			disc_s1 <= (cfg.mode == MODE_DISC);
			side_s1 <= side_c;

			dx2_s2  <= PROD_W'(dx_s1) * PROD_W'(dx_s1);
			dy2_s2  <= PROD_W'(dy_s1) * PROD_W'(dy_s1);
			r2_s2   <= PROD_W'(cfg.radius) * PROD_W'(cfg.radius);
			disc_s2 <= disc_s1;
			side_s2 <= side_s1;

			sum_s3  <= sum_c;
			side_s3 <= side_s2_next;
		end
	end

	assign out_valid = vld_s3;
	assign sum_sq    = sum_s3;
	assign side      = side_s3;

endmodule

// ----- rtl/core/prma_sqrt.sv -----
// Pipelined integer square root of the squared distance with eight fractional
// bits, one result bit per register stage. Depends on prma_pkg.
module prma_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [prma_pkg::SQ_W-1:0]   sum_sq,
	input  prma_pkg::side_t             side_in,
	output logic                        out_valid,
	output logic [prma_pkg::ROOT_W-1:0] dist_q8,
	output prma_pkg::side_t             side_out
);
	import prma_pkg::*;

	localparam int STEPS   = ROOT_W;
	localparam int RADIX_W = 2 * ROOT_W;

	logic [RADIX_W-1:0] rad_i  [STEPS];
	logic [ROOT_W:0]    rem_i  [STEPS];
	logic [ROOT_W-1:0]  root_i [STEPS];
	side_t              side_i [STEPS];
	logic [STEPS-1:0]   vld_i;

	logic [RADIX_W-1:0] rad_s  [STEPS];
	logic [ROOT_W:0]    rem_s  [STEPS];
	logic [ROOT_W-1:0]  root_s [STEPS];
	side_t              side_s [STEPS];
	logic [STEPS-1:0]   vld_s;

	genvar k;
	generate
		for (k = 0; k < STEPS; k++) begin : g_step
			logic [1:0]        pair;
			logic [ROOT_W+2:0] rem_sh, trial;
			logic              take;

			if (k == 0) begin : g_head
				// The radicand is the squared distance scaled by 2^(2*FRAC_BITS).
				assign rad_i[k]  = RADIX_W'({sum_sq, {(2 * FRAC_BITS){1'b0}}});
				assign rem_i[k]  = '0;
				assign root_i[k] = '0;
				assign side_i[k] = side_in;
				assign vld_i[k]  = in_valid;
			end else begin : g_link
				assign rad_i[k]  = rad_s[k-1];
				assign rem_i[k]  = rem_s[k-1];
				assign root_i[k] = root_s[k-1];
				assign side_i[k] = side_s[k-1];
				assign vld_i[k]  = vld_s[k-1];
			end

			assign pair   = rad_i[k][2 * (STEPS - 1 - k) +: 2];
			assign rem_sh = {rem_i[k], pair};
			assign trial  = {1'b0, root_i[k], 2'b01};
			assign take   = (rem_sh >= trial);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_i[k];
				end
			end

			// The remainder never exceeds twice the partial root, so it fits ROOT_W+1 bits.
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k]  <= rad_i[k];
					rem_s[k]  <= take ? (rem_sh[ROOT_W:0] - trial[ROOT_W:0]) : rem_sh[ROOT_W:0];
					root_s[k] <= {root_i[k][ROOT_W-2:0], take};
					side_s[k] <= side_i[k];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[STEPS-1];
	assign dist_q8   = root_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];

endmodule

// ----- rtl/core/prma_cone.sv -----
// Cone falloff: floor(255 * (R - d) / R) by restoring division, one quotient
// bit per register stage after two setup stages. Depends on prma_pkg.
module prma_cone (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [prma_pkg::ROOT_W-1:0]     dist_q8,
	input  prma_pkg::side_t                 side_in,
	input  logic [prma_pkg::COORD_BITS-1:0] radius,
	output logic                            out_valid,
	output prma_pkg::side_t                 side_out
);
	import prma_pkg::*;

	localparam int NUM_W = RAD_W + QUO_W;

	logic [RAD_W-1:0] big_r;
	logic             live_c;
	logic [NUM_W-1:0] num_c;

	logic             vld_s1, live_s1;
	logic [RAD_W-1:0] diff_s1;
	side_t            side_s1;

	logic             vld_s2, live_s2;
	logic [RAD_W-1:0] rem_s2;
	logic [QUO_W-1:0] low_s2;
	side_t            side_s2;

	logic [QUO_W-1:0] vld_i, live_i;
	logic [RAD_W-1:0] rem_i  [QUO_W];
	logic [QUO_W-1:0] low_i  [QUO_W];
	logic [QUO_W-1:0] quo_i  [QUO_W];
	side_t            side_i [QUO_W];

	logic [QUO_W-1:0] vld_d, live_d;
	logic [RAD_W-1:0] rem_d  [QUO_W];
	logic [QUO_W-1:0] low_d  [QUO_W];
	logic [QUO_W-1:0] quo_d  [QUO_W];
	side_t            side_d [QUO_W];

	assign big_r  = {radius, {FRAC_BITS{1'b0}}};
	assign live_c = side_in.cone && (big_r != '0) && (dist_q8 < ROOT_W'(big_r));
	// 255 * n taken as n * 256 - n.
	assign num_c  = {diff_s1, {QUO_W{1'b0}}} - NUM_W'(diff_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			live_s1 <= live_c;
			diff_s1 <= big_r - dist_q8[RAD_W-1:0];
			side_s1 <= side_in;
			// The quotient stays below 256, so the upper part starts below R.
			live_s2 <= live_s1;
			rem_s2  <= num_c[NUM_W-1:QUO_W];
			low_s2  <= num_c[QUO_W-1:0];
			side_s2 <= side_s1;
		end
	end

	genvar j;
	generate
		for (j = 0; j < QUO_W; j++) begin : g_div
			logic [RAD_W:0] rem_sh;
			logic           take;

			if (j == 0) begin : g_head
				assign vld_i[j]  = vld_s2;
				assign live_i[j] = live_s2;
				assign rem_i[j]  = rem_s2;
				assign low_i[j]  = low_s2;
				assign quo_i[j]  = '0;
				assign side_i[j] = side_s2;
			end else begin : g_link
				assign vld_i[j]  = vld_d[j-1];
				assign live_i[j] = live_d[j-1];
				assign rem_i[j]  = rem_d[j-1];
				assign low_i[j]  = low_d[j-1];
				assign quo_i[j]  = quo_d[j-1];
				assign side_i[j] = side_d[j-1];
			end

			assign rem_sh = {rem_i[j], low_i[j][QUO_W-1-j]};
			assign take   = (rem_sh >= {1'b0, big_r});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_d[j] <= 1'b0;
				end else if (en) begin
					vld_d[j] <= vld_i[j];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					live_d[j] <= live_i[j];
					rem_d[j]  <= take ? (rem_sh[RAD_W-1:0] - big_r) : rem_sh[RAD_W-1:0];
					low_d[j]  <= low_i[j];
					quo_d[j]  <= {quo_i[j][QUO_W-2:0], take};
					side_d[j] <= side_i[j];
				end
			end
		end
	endgenerate

	always_comb begin
		side_out = side_d[QUO_W-1];
		if (side_d[QUO_W-1].cone) begin
			side_out.mask = live_d[QUO_W-1] ? quo_d[QUO_W-1] : MASK_NONE;
		end
	end

	assign out_valid = vld_d[QUO_W-1];

endmodule

// ----- rtl/core/prma_scale.sv -----
// Channel scaling: each channel times the mask, divided by 255 with the
// reciprocal identity for 8-bit products. Two register stages. Depends on prma_pkg.
module prma_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  prma_pkg::side_t side_in,
	output logic            out_valid,
	output logic [7:0]      chan_a,
	output logic [7:0]      chan_b,
	output logic [7:0]      chan_c,
	output logic [7:0]      mask
);
	import prma_pkg::*;

	logic        vld_s1, vld_s2;
	logic [15:0] pa_s1, pb_s1, pc_s1;
	logic [7:0]  mask_s1;
	logic [7:0]  a_s2, b_s2, c_s2, mask_s2;

	// Exact floor(x / 255) for any x up to 255 * 255, the largest product of two 8-bit values.
	function automatic logic [7:0] div_by_255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1;
		t = t + (t >> 8);
		return t[15:8];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1   <= 16'(side_in.chan_a) * 16'(side_in.mask);
			pb_s1   <= 16'(side_in.chan_b) * 16'(side_in.mask);
			pc_s1   <= 16'(side_in.chan_c) * 16'(side_in.mask);
			mask_s1 <= side_in.mask;
			a_s2    <= div_by_255(pa_s1);
			b_s2    <= div_by_255(pb_s1);
			c_s2    <= div_by_255(pc_s1);
			mask_s2 <= mask_s1;
		end
	end

	assign out_valid = vld_s2;
	assign chan_a    = a_s2;
	assign chan_b    = b_s2;
	assign chan_c    = c_s2;
	assign mask      = mask_s2;

endmodule
